[hdl/pfba_pkg.sv]
package pfba_pkg;

  localparam int ADDR_W      = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int FRAME_BYTES = 4096;
  localparam int IDX_W       = ADDR_W - FRAME_SHIFT + 1;
  localparam int WORD_BITS   = 64;
  localparam int POS_W       = 6;
  localparam int FADDR_W     = 24;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [1:0] OP_CLAIM_AT     = 2'd0;
  localparam logic [1:0] OP_CLAIM_RANGE  = 2'd1;
  localparam logic [1:0] OP_CLAIM_LOWEST = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FAIL      = 3'd1,
    ST_IN_USE    = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NONE_FREE = 3'd4
  } status_t;

  typedef struct packed {
    word_t             new_word;
    logic              hit;
    logic              conflict;
    logic [POS_W-1:0]  pos;
  } claim_t;

endpackage

[hdl/page_frame_bitmap_allocator.sv]
// Page frame bitmap allocator: one used bit per 4 KiB frame, kept in a
// memory of 64-bit words.
// Request channel: in_valid/in_stall with op, start_addr, end_addr. A request
// is taken when in_valid is high and in_stall low. Result channel:
// out_valid/out_stall with status and frame_addr, one result per request.
// Steps: a single-frame claim passes the read, modify and response states.
// A range claim reads and modifies each bitmap word it touches in turn. A
// lowest-free claim scans words from word 0 until one has a free bit or the
// last word is seen. Requests settled at decode (misaligned, out of range,
// empty range, unused op) go straight to the response state.
// The bitmap memory has one read and one write port and walks one word per
// cycle. One request is in work at a time; the next is taken once the
// current result sits in the output register.
// Reset: a clearing pass writes every word of the bitmap, with in_stall high
// until it ends.
// A stalled result holds in the output register; at most one more request
// is taken and its result waits until the register is free.
module page_frame_bitmap_allocator #(
  parameter int FRAME_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] start_addr,
  input  logic [31:0] end_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [23:0] frame_addr
);
  import pfba_pkg::*;

  localparam int WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TAIL  = FRAME_COUNT % WORD_BITS;
  localparam word_t PAD = (TAIL == 0) ? '0 : ~((word_t'(1) << TAIL) - word_t'(1));
  localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);
  localparam logic [IDX_W-1:0] FC_I = IDX_W'(FRAME_COUNT);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MOD, S_RESP} state_t;

  state_t            state;
  logic [AW-1:0]     clr_idx;
  logic [AW-1:0]     word_idx;
  logic [AW-1:0]     end_word;
  logic [POS_W-1:0]  lo_off;
  logic [POS_W-1:0]  end_off;
  logic              search_q;
  logic              single_q;
  logic              over_q;
  status_t           res_status;
  logic [FADDR_W-1:0] res_addr;

  word_t             mem [WORDS];
  word_t             rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     word_nxt;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  word_t             mem_wdata;

  word_t             mask;
  claim_t            claim;

  logic [IDX_W-1:0]  first;
  logic [32:0]       end_sum;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  stop;
  logic [IDX_W-1:0]  stop_m1;
  logic [AW+POS_W+FRAME_SHIFT-1:0] found_addr;

  always_comb begin
    first   = {1'b0, start_addr[31:12]};
    end_sum = {1'b0, end_addr} + 33'(FRAME_BYTES - 1);
    last    = end_sum[32:12];
    if (op == OP_CLAIM_AT) begin
      stop = first + IDX_W'(1);
    end else begin
      stop = (last > FC_I) ? FC_I : last;
    end
    stop_m1 = stop - IDX_W'(1);
  end

  always_comb begin
    word_nxt = (word_idx == LAST_W) ? '0 : word_idx + AW'(1);
    rd_addr  = (state == S_MOD) ? word_nxt : word_idx;
    mask = ('1 << lo_off) &
           ((word_idx == end_word) ? ('1 >> (POS_W'(WORD_BITS - 1) - end_off)) : '1);
    found_addr = {word_idx, claim.pos, {FRAME_SHIFT{1'b0}}};
    mem_we    = 1'b0;
    mem_waddr = word_idx;
    mem_wdata = claim.new_word;
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = (clr_idx == LAST_W) ? PAD : '0;
    end else if (state == S_MOD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  pfba_word_claim u_claim (
    .rd_word (rdata),
    .mask    (mask),
    .search  (search_q),
    .res     (claim)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_idx == LAST_W) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_addr <= '0;
            search_q <= 1'b0;
            single_q <= (op == OP_CLAIM_AT);
            over_q   <= (op == OP_CLAIM_RANGE) && (last > FC_I);
            word_idx <= AW'(first >> POS_W);
            lo_off   <= first[POS_W-1:0];
            end_word <= AW'(stop_m1 >> POS_W);
            end_off  <= stop_m1[POS_W-1:0];
            case (op)
              OP_CLAIM_AT: begin
                if (start_addr[FRAME_SHIFT-1:0] != '0) begin
                  res_status <= ST_FAIL;
                  state      <= S_RESP;
                end else if (first >= FC_I) begin
                  res_status <= ST_RANGE;
                  state      <= S_RESP;
                end else begin
                  state <= S_RD;
                end
              end
              OP_CLAIM_RANGE: begin
                if (first >= last) begin
                  res_status <= ST_OK;
                  state      <= S_RESP;
                end else if (first >= FC_I) begin
                  res_status <= ST_RANGE;
                  state      <= S_RESP;
                end else begin
                  state <= S_RD;
                end
              end
              OP_CLAIM_LOWEST: begin
                search_q <= 1'b1;
                word_idx <= '0;
                state    <= S_RD;
              end
              default: begin
                res_status <= ST_FAIL;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (search_q) begin
            if (claim.hit) begin
              res_status <= ST_OK;
              res_addr   <= FADDR_W'(found_addr);
              state      <= S_RESP;
            end else if (word_idx == LAST_W) begin
              res_status <= ST_NONE_FREE;
              state      <= S_RESP;
            end else begin
              word_idx <= word_nxt;
            end
          end else begin
            if (claim.conflict) begin
              res_status <= single_q ? ST_IN_USE : ST_FAIL;
              state      <= S_RESP;
            end else if (word_idx == end_word) begin
              res_status <= over_q ? ST_RANGE : ST_OK;
              state      <= S_RESP;
            end else begin
              word_idx <= word_nxt;
              lo_off   <= '0;
            end
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            frame_addr <= res_addr;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_range_within_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && !search_q) |-> (word_idx <= end_word))
    else $error("range walk passed its last word");

  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_addr != '0) |-> (status == ST_OK))
    else $error("frame address given with a failing status");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_CLR && state != S_CLR) |-> ($past(clr_idx) == LAST_W))
    else $error("clearing pass ended early");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (!out_valid || !out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");

endmodule

[hdl/pfba_word_claim.sv]
module pfba_word_claim (
  input  logic [63:0]     rd_word,
  input  logic [63:0]     mask,
  input  logic            search,
  output pfba_pkg::claim_t res
);
  import pfba_pkg::*;

  word_t free_bits;
  word_t free_low;
  word_t used_bits;
  word_t used_low;
  word_t claim_bits;
  logic [POS_W-1:0] pos;

  always_comb begin
    free_bits  = ~rd_word;
    free_low   = free_bits & (~free_bits + word_t'(1));
    used_bits  = rd_word & mask;
    used_low   = used_bits & (~used_bits + word_t'(1));
    claim_bits = mask & (used_low - word_t'(1));
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (free_low[j]) begin
        pos = pos | POS_W'(j);
      end
    end
    res.hit      = |free_bits;
    res.conflict = |used_bits;
    res.pos      = pos;
    res.new_word = search ? (rd_word | free_low) : (rd_word | claim_bits);
  end

endmodule
